FILE: rtl/assert_macros.svh
// Assertion macros for the checker file of the derivative bound block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SDB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("port level check failed");

// Next-cycle implication, disabled while reset is high.
`define SDB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("port level check failed");

`endif

FILE: rtl/sdb_pkg.sv
// Shared types and constants for the derivative bound block.
// No dependencies; imported by every module of the block.
package sdb_pkg;

  localparam int MIN_DEN_W = 17;  // min_denominator register width
  localparam int FACTOR_W  = 8;   // basis_factor width
  localparam int DIR_W     = 3;   // direction width
  localparam int CFG_IDX_W = 1;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASIS_KIND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DEN    = 1'b1;

  // basis_kind codes
  localparam logic BASIS_BEZIER  = 1'b0;
  localparam logic BASIS_BSPLINE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_MAG,
    S_MUL,
    S_DIV,
    S_FIN,
    S_UPD
  } sdb_state_t;

  typedef struct packed {
    logic load;  // capture input word
    logic diff;  // differences and divisor select
    logic mag;   // magnitude, sign, cap
    logic mul;   // product, divider init
    logic div;   // one divider step
    logic fin;   // clamp and sign
    logic upd;   // bounds update and output load
  } sdb_cmd_t;

  typedef struct packed {
    logic skip_div;
    logic div_last;
    logic out_free;
  } sdb_status_t;

endpackage

FILE: rtl/sdb_ctrl.sv
// Sequencer for the derivative bound block: one item at a time.
// Depends on sdb_pkg (state enum, command and status structs).
module sdb_ctrl
  import sdb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  sdb_status_t status,
  output sdb_cmd_t    cmd
);

  sdb_state_t state;
  sdb_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_DIFF;
      S_DIFF: state_next = S_MAG;
      S_MAG:  state_next = S_MUL;
      S_MUL:  state_next = status.skip_div ? S_FIN : S_DIV;
      S_DIV:  if (status.div_last) state_next = S_FIN;
      S_FIN:  state_next = S_UPD;
      S_UPD:  if (status.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DIFF: cmd.diff = 1'b1;
      S_MAG:  cmd.mag  = 1'b1;
      S_MUL:  cmd.mul  = 1'b1;
      S_DIV:  cmd.div  = 1'b1;
      S_FIN:  cmd.fin  = 1'b1;
      S_UPD:  cmd.upd  = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: rtl/sdb_datapath.sv
// Arithmetic datapath: difference, product, radix-2 restoring divide, clamp.
// Depends on sdb_pkg (command struct, field widths, basis codes).
module sdb_datapath
  import sdb_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  sdb_cmd_t                      cmd,
  input  logic                          basis_kind,
  input  logic [MIN_DEN_W-1:0]          min_den,
  input  logic signed [VALUE_WIDTH-1:0] point_current,
  input  logic signed [VALUE_WIDTH-1:0] point_next,
  input  logic signed [VALUE_WIDTH-1:0] knot_high,
  input  logic signed [VALUE_WIDTH-1:0] knot_low,
  input  logic [FACTOR_W-1:0]           basis_factor,
  output logic                          skip_div,
  output logic                          div_last,
  output logic signed [VALUE_WIDTH-1:0] derivative,
  output logic                          saturated
);

  localparam int VW     = VALUE_WIDTH;
  localparam int PROD_W = VW + FACTOR_W;
  localparam int N      = PROD_W + FRAC_BITS;           // divide steps
  localparam int DEN_W  = (VW > MIN_DEN_W) ? VW : MIN_DEN_W;
  localparam int CMP_W  = DEN_W + 2;
  localparam int CNT_W  = $clog2(N + 1);

  // captured item
  logic signed [VW-1:0]   cur_r, nxt_r, kh_r, kl_r;
  logic [FACTOR_W-1:0]    factor_r;

  logic signed [VW:0]     diff;
  logic [DEN_W-1:0]       den;
  logic                   neg;
  logic [VW-1:0]          mag;
  logic [VW-1:0]          cap;
  logic [PROD_W-1:0]      prod;

  // divider
  logic [N-1:0]           dvd;
  logic [DEN_W-1:0]       rem;
  logic [VW:0]            quo;
  logic                   over;
  logic [CNT_W-1:0]       cnt;

  // combinational
  logic signed [VW:0]     diff_w, span_w, neg_diff;
  logic [MIN_DEN_W-1:0]   md_eff;
  logic signed [CMP_W-1:0] span_x, md_x;
  logic [DEN_W-1:0]       den_w;
  logic [PROD_W-1:0]      prod_w;
  logic [DEN_W:0]         rs, rs_sub;
  logic                   ge;
  logic [VW+1:0]          qs;
  logic [VW:0]            cap_p1;
  logic                   step_over;
  logic [VW-1:0]          mag_f;
  logic                   sat_f;

  assign skip_div = (factor_r == '0) || (basis_kind == BASIS_BEZIER);
  assign div_last = (cnt == CNT_W'(1));

  always_comb begin
    diff_w   = $signed({nxt_r[VW-1], nxt_r}) - $signed({cur_r[VW-1], cur_r});
    span_w   = $signed({kh_r[VW-1], kh_r}) - $signed({kl_r[VW-1], kl_r});
    md_eff   = (min_den == '0) ? MIN_DEN_W'(1) : min_den;
    span_x   = CMP_W'(span_w);
    md_x     = $signed(CMP_W'(md_eff));
    den_w    = (span_x > md_x) ? DEN_W'($unsigned(span_w)) : DEN_W'(md_eff);
    neg_diff = -diff;
    prod_w   = PROD_W'(factor_r) * PROD_W'(mag);
  end

  // one restoring step with the quotient held at cap+1 once it runs past cap
  always_comb begin
    rs        = {rem, dvd[N-1]};
    rs_sub    = rs - {1'b0, den};
    ge        = (rs >= {1'b0, den});
    qs        = {quo, ge};
    cap_p1    = {1'b0, cap} + (VW+1)'(1);
    step_over = (qs > (VW+2)'(cap));
  end

  always_comb begin
    mag_f = '0;
    sat_f = 1'b0;
    if (factor_r == '0) begin
      mag_f = '0;
    end else if (basis_kind == BASIS_BEZIER) begin
      if (prod > PROD_W'(cap)) begin
        mag_f = cap;
        sat_f = 1'b1;
      end else begin
        mag_f = prod[VW-1:0];
      end
    end else if (over) begin
      mag_f = cap;
      sat_f = 1'b1;
    end else begin
      mag_f = quo[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r    <= point_current;
      nxt_r    <= point_next;
      kh_r     <= knot_high;
      kl_r     <= knot_low;
      factor_r <= basis_factor;
    end
    if (cmd.diff) begin
      diff <= diff_w;
      den  <= den_w;
    end
    if (cmd.mag) begin
      neg <= diff[VW];
      mag <= diff[VW] ? neg_diff[VW-1:0] : diff[VW-1:0];
      cap <= diff[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end
    if (cmd.mul) begin
      prod <= prod_w;
      dvd  <= {prod_w, {FRAC_BITS{1'b0}}};
      rem  <= '0;
      quo  <= '0;
      over <= 1'b0;
      cnt  <= CNT_W'(N);
    end
    if (cmd.div) begin
      dvd  <= {dvd[N-2:0], 1'b0};
      rem  <= ge ? rs_sub[DEN_W-1:0] : rs[DEN_W-1:0];
      quo  <= step_over ? cap_p1 : qs[VW:0];
      over <= over | step_over;
      cnt  <= cnt - CNT_W'(1);
    end
    if (cmd.fin) begin
      derivative <= neg ? -$signed(mag_f) : $signed(mag_f);
      saturated  <= sat_f;
    end
  end

endmodule

FILE: rtl/sdb_bounds.sv
// Per-direction running min/max store and the output word register.
// Depends on sdb_pkg (command struct, direction width).
module sdb_bounds
  import sdb_pkg::*;
#(
  parameter int MAX_DIM     = 8,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sdb_cmd_t                      cmd,
  input  logic [DIR_W-1:0]              direction,
  input  logic                          last,
  input  logic signed [VALUE_WIDTH-1:0] derivative,
  input  logic                          saturated,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_free,
  output logic signed [VALUE_WIDTH-1:0] out_derivative,
  output logic                          out_saturated,
  output logic signed [VALUE_WIDTH-1:0] out_min,
  output logic signed [VALUE_WIDTH-1:0] out_max,
  output logic                          out_last
);

  localparam int VW    = VALUE_WIDTH;
  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  logic signed [VW-1:0] rmin [MAX_DIM];
  logic signed [VW-1:0] rmax [MAX_DIM];
  logic [DIR_W-1:0]     dir_r;
  logic                 last_r;

  logic                 in_range;
  logic [IDX_W-1:0]     idx;
  logic signed [VW-1:0] new_min, new_max;
  logic                 fire;

  always_comb begin
    in_range = (int'(dir_r) < MAX_DIM);
    idx      = IDX_W'(dir_r);
    new_min  = (derivative < rmin[idx]) ? derivative : rmin[idx];
    new_max  = (derivative > rmax[idx]) ? derivative : rmax[idx];
    out_free = !out_valid || out_ready;
    fire     = cmd.upd && out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dir_r  <= direction;
      last_r <= last;
    end
    if (fire) begin
      out_derivative <= derivative;
      out_saturated  <= saturated;
      out_min        <= in_range ? new_min : VMAX;
      out_max        <= in_range ? new_max : VMIN;
      out_last       <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int d = 0; d < MAX_DIM; d++) begin
        rmin[d] <= VMAX;
        rmax[d] <= VMIN;
      end
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (fire && last_r) begin
        for (int d = 0; d < MAX_DIM; d++) begin
          rmin[d] <= VMAX;
          rmax[d] <= VMIN;
        end
      end else if (fire && in_range) begin
        rmin[idx] <= new_min;
        rmax[idx] <= new_max;
      end
    end
  end

endmodule

FILE: rtl/spline_derivative_bound.sv
// Derivative control points of a B-spline or Bezier curve, with per-direction
// running bounds. Each accepted word carries two neighboring control-point
// coordinates, the two knots bounding the derivative support, a basis factor
// and a direction. The result is factor*(next-current) in Bezier mode, and
// factor*(next-current)/max(knot_high-knot_low, min_denominator) in B-spline
// mode, signed fixed point with FRAC_BITS fraction bits, clamped to the
// VALUE_WIDTH signed range with tuser set when clamped. A zero factor gives 0.
// Each result also carries the running min and max for its direction (this
// item included); a direction at or above MAX_DIM reports the empty bounds
// (most positive min, most negative max). After a word with tlast set all
// directions return to the empty bounds. One item is in flight at a time.
// B-spline items with a nonzero factor pass through the radix-2 divider,
// which retires one quotient bit a cycle over VALUE_WIDTH+8+FRAC_BITS
// dividend bits; Bezier items and zero-factor items skip it. The result
// register lets the next word be taken while a finished result waits on
// m_axis_tready.
// Config writes (cfg_index 0: basis_kind, 1: min_denominator) are always
// accepted and must only be issued while the block is idle.
module spline_derivative_bound
  import sdb_pkg::*;
#(
  parameter int MAX_DIM     = 8,
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // point_current, point_next, knot_high, knot_low, basis_factor, zero pad
  input  logic [((4*VALUE_WIDTH+FACTOR_W+7)/8)*8-1:0] s_axis_tdata,
  // direction
  input  logic [DIR_W-1:0]                     s_axis_tuser,
  input  logic                                 s_axis_tlast,
  // output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // derivative, min_value, max_value, zero pad
  output logic [((3*VALUE_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
  // saturated
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tlast,
  // config write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [CFG_IDX_W-1:0]                 cfg_index,
  input  logic [MIN_DEN_W-1:0]                 cfg_data
);

  localparam int VW         = VALUE_WIDTH;
  localparam int OUT_DATA_W = ((3*VALUE_WIDTH+7)/8)*8;

  // config registers
  logic                 basis_kind;
  logic [MIN_DEN_W-1:0] min_den;

  sdb_cmd_t    cmd;
  sdb_status_t status;
  logic        skip_div, div_last, out_free;

  logic signed [VW-1:0] derivative;
  logic                 saturated;
  logic signed [VW-1:0] out_derivative, out_min, out_max;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      basis_kind <= BASIS_BSPLINE;
      min_den    <= MIN_DEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BASIS_KIND: basis_kind <= cfg_data[0];
        CFG_MIN_DEN:    min_den    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign status.skip_div = skip_div;
  assign status.div_last = div_last;
  assign status.out_free = out_free;

  sdb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sdb_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk           (clk),
    .cmd           (cmd),
    .basis_kind    (basis_kind),
    .min_den       (min_den),
    .point_current ($signed(s_axis_tdata[VW-1:0])),
    .point_next    ($signed(s_axis_tdata[2*VW-1:VW])),
    .knot_high     ($signed(s_axis_tdata[3*VW-1:2*VW])),
    .knot_low      ($signed(s_axis_tdata[4*VW-1:3*VW])),
    .basis_factor  (s_axis_tdata[4*VW+FACTOR_W-1:4*VW]),
    .skip_div      (skip_div),
    .div_last      (div_last),
    .derivative    (derivative),
    .saturated     (saturated)
  );

  sdb_bounds #(
    .MAX_DIM     (MAX_DIM),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_bounds (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .direction      (s_axis_tuser),
    .last           (s_axis_tlast),
    .derivative     (derivative),
    .saturated      (saturated),
    .out_ready      (m_axis_tready),
    .out_valid      (m_axis_tvalid),
    .out_free       (out_free),
    .out_derivative (out_derivative),
    .out_saturated  (m_axis_tuser),
    .out_min        (out_min),
    .out_max        (out_max),
    .out_last       (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_DATA_W'({out_max, out_min, out_derivative});

endmodule

FILE: rtl/sdb_checker.sv
// Port-level checks for the derivative bound block, bound to its top level.
// Depends on sdb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sdb_checker
  import sdb_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [((3*VALUE_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
  input logic                                m_axis_tuser
);

  localparam int VW = VALUE_WIDTH;
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  logic signed [VW-1:0] der, lo, hi;
  logic                 bounds_ok, sat_ok;

  assign der = $signed(m_axis_tdata[VW-1:0]);
  assign lo  = $signed(m_axis_tdata[2*VW-1:VW]);
  assign hi  = $signed(m_axis_tdata[3*VW-1:2*VW]);

  // bounds either ordered or the empty pair of an unknown direction
  assign bounds_ok = (lo <= hi) || ((lo == VMAX) && (hi == VMIN));
  // a clamped result sits on one of the range ends
  assign sat_ok    = (der == VMAX) || (der == VMIN);

  `SDB_ASSERT_IMP(a_bounds_order, clk, rst, m_axis_tvalid, bounds_ok)
  `SDB_ASSERT_IMP(a_sat_clamped, clk, rst, m_axis_tvalid && m_axis_tuser, sat_ok)
  `SDB_ASSERT_NXT(a_one_in_flight, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `SDB_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind spline_derivative_bound sdb_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_sdb_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: verif/tb_spline_derivative_bound.sv
// Self-checking testbench for spline_derivative_bound: directed table plus random phases,
// every result word checked against a local bounds predictor, and its derivative against the predictor or the table.
// Depends on sdb_pkg and the spline_derivative_bound RTL only.
module tb_spline_derivative_bound
  import sdb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW          = 32;
  localparam int FRAC        = 16;
  localparam int NUM_DIRS    = 8;
  localparam int IN_W        = ((4*VW+FACTOR_W+7)/8)*8;
  localparam int OUT_W       = ((3*VW+7)/8)*8;
  localparam int PHASE_WORDS = 275;
  localparam int TAIL_CYCLES = 80;
  localparam int CYCLE_LIMIT = 1000000;

  localparam logic signed [VW-1:0] VMAX = 32'sh7FFF_FFFF;
  localparam logic signed [VW-1:0] VMIN = 32'sh8000_0000;
  localparam logic signed [VW-1:0] ONE  = 32'sh0001_0000;  // 1.0 in Q16.16

  // one input word: a neighbor pair of control points with its knot span
  typedef struct packed {
    logic signed [VW-1:0] cur;
    logic signed [VW-1:0] nxt;
    logic signed [VW-1:0] khi;
    logic signed [VW-1:0] klo;
    logic [FACTOR_W-1:0]  factor;
    logic [DIR_W-1:0]     dir;
    logic                 last;
  } ctrl_pair_t;

  // one result word: derivative point plus the bounds of its direction
  typedef struct packed {
    logic signed [VW-1:0] deriv;
    logic                 sat;
    logic signed [VW-1:0] lo;
    logic signed [VW-1:0] hi;
    logic                 last;
  } deriv_word_t;

  // directed row: basis to run under, the word, and an optional typed answer
  typedef struct packed {
    logic                 kind;
    ctrl_pair_t           pair;
    logic                 typed;
    logic signed [VW-1:0] t_der;
    logic                 t_sat;
  } dir_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_W-1:0]        s_axis_tdata;
  logic [DIR_W-1:0]       s_axis_tuser;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_W-1:0]       m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [MIN_DEN_W-1:0]   cfg_data;

  // predictor state: register copies and per-direction running bounds
  logic                   basis_sel;
  logic [MIN_DEN_W-1:0]   min_den;
  logic signed [VW-1:0]   dir_min [NUM_DIRS];
  logic signed [VW-1:0]   dir_max [NUM_DIRS];

  deriv_word_t            pending_derivs [$];
  dir_row_t               directed_rows [$];
  int                     fail_count;
  int                     cycle_count;
  bit                     gaps_on;

  spline_derivative_bound DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // empty bounds: min at the top of the range, max at the bottom
  function automatic void clear_dir_bounds();
    for (int d = 0; d < NUM_DIRS; d++) begin
      dir_min[d] = VMAX;
      dir_max[d] = VMIN;
    end
  endfunction

  // Derivative of one pair under the current register copies. The divide is
  // exact 64-bit math: the clamp only cares whether the true quotient passed
  // the cap, so no bitwise divider is needed here. Updates running bounds.
  function automatic deriv_word_t derive_point(ctrl_pair_t p);
    longint      diff;
    longint      span;
    longint      den_s;
    longint      signed_mag;
    logic [63:0] abs_diff;
    logic [63:0] prod;
    logic [63:0] cap;
    logic [63:0] mag;
    logic [63:0] quot;
    logic [63:0] den;
    bit          neg;
    deriv_word_t r;
    diff     = longint'(p.nxt) - longint'(p.cur);
    neg      = diff < 0;
    cap      = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;  // negative side reaches one further
    abs_diff = neg ? -diff : diff;
    prod     = 64'(p.factor) * abs_diff;
    r.sat    = 1'b0;
    if (p.factor == 0) begin
      mag = 64'd0;
    end else if (basis_sel == BASIS_BEZIER) begin
      mag = prod;
      if (mag > cap) begin
        r.sat = 1'b1;
        mag   = cap;
      end
    end else begin
      span  = longint'(p.khi) - longint'(p.klo);
      den_s = (min_den == 0) ? 64'sd1 : longint'({47'd0, min_den});
      if (span > den_s) den_s = span;
      den  = den_s;
      quot = (prod << FRAC) / den;
      if (quot > cap) begin
        r.sat = 1'b1;
        mag   = cap;
      end else begin
        mag = quot;
      end
    end
    signed_mag = neg ? -longint'(mag) : longint'(mag);
    r.deriv    = signed_mag[VW-1:0];
    // 3-bit direction always indexes a tracked direction at NUM_DIRS = 8
    if (r.deriv < dir_min[p.dir]) dir_min[p.dir] = r.deriv;
    if (r.deriv > dir_max[p.dir]) dir_max[p.dir] = r.deriv;
    r.lo   = dir_min[p.dir];
    r.hi   = dir_max[p.dir];
    r.last = p.last;
    if (p.last) clear_dir_bounds();
    return r;
  endfunction

  // Random pair. Arithmetic shifts of random words spread the magnitudes so
  // both clamped and in-range results show up; most knot pairs are ordered
  // with a positive span of at most 16.0, the rest are arbitrary.
  function automatic ctrl_pair_t random_pair();
    ctrl_pair_t p;
    int         pick;
    pick = $urandom_range(9);
    if (pick < 2) begin
      p.cur = $urandom;
      p.nxt = $urandom;
    end else begin
      p.cur = $signed($urandom) >>> $urandom_range(0, 31);
      p.nxt = $signed($urandom) >>> $urandom_range(0, 31);
    end
    if ($urandom_range(9) < 7) begin
      p.klo = $signed($urandom) >>> $urandom_range(8, 31);
      p.khi = p.klo + $urandom_range(1, 1 << 20);
    end else begin
      p.klo = $signed($urandom) >>> $urandom_range(0, 31);
      p.khi = $signed($urandom) >>> $urandom_range(0, 31);
    end
    pick = $urandom_range(9);
    if (pick == 0)     p.factor = '0;
    else if (pick < 6) p.factor = FACTOR_W'($urandom_range(1, 7));
    else               p.factor = FACTOR_W'($urandom_range(0, 255));
    p.dir  = DIR_W'($urandom_range(0, NUM_DIRS - 1));
    p.last = ($urandom_range(15) == 0);
    return p;
  endfunction

  function automatic void add_row(logic kind, logic signed [VW-1:0] cur,
                                  logic signed [VW-1:0] nxt, logic signed [VW-1:0] khi,
                                  logic signed [VW-1:0] klo, int factor, int dir, bit last,
                                  bit typed, logic signed [VW-1:0] t_der, bit t_sat);
    dir_row_t r;
    r.kind        = kind;
    r.pair.cur    = cur;
    r.pair.nxt    = nxt;
    r.pair.khi    = khi;
    r.pair.klo    = klo;
    r.pair.factor = FACTOR_W'(factor);
    r.pair.dir    = DIR_W'(dir);
    r.pair.last   = last;
    r.typed       = typed;
    r.t_der       = t_der;
    r.t_sat       = t_sat;
    directed_rows.push_back(r);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with tvalid still high; a gap in the next call, or a drain, lowers it.
  task automatic send_pair(ctrl_pair_t p, bit typed, logic signed [VW-1:0] t_der,
                           bit t_sat);
    deriv_word_t want;
    while (gaps_on && $urandom_range(99) < 30) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {p.factor, p.klo, p.khi, p.nxt, p.cur};
    s_axis_tuser  = p.dir;
    s_axis_tlast  = p.last;
    do @(posedge clk); while (!s_axis_tready);
    want = derive_point(p);
    if (typed) begin
      want.deriv = t_der;
      want.sat   = t_sat;
    end
    pending_derivs.push_back(want);
    @(negedge clk);
  endtask

  // sender holds off until every word in flight has come back
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending_derivs.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MIN_DEN_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_BASIS_KIND) basis_sel = val[0];
    else                       min_den   = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // receiver stalls, same duty as the sender gaps
  always @(negedge clk) begin
    m_axis_tready <= gaps_on ? ($urandom_range(99) >= 30) : 1'b1;
  end

  // result checker: every accepted word against the oldest expectation
  always @(posedge clk) begin
    deriv_word_t          want;
    logic signed [VW-1:0] got_der;
    logic signed [VW-1:0] got_lo;
    logic signed [VW-1:0] got_hi;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_der = m_axis_tdata[VW-1:0];
      got_lo  = m_axis_tdata[2*VW-1:VW];
      got_hi  = m_axis_tdata[3*VW-1:2*VW];
      if (pending_derivs.size() == 0) begin
        $error("result word with no expectation waiting: derivative %0d", got_der);
        fail_count++;
      end else begin
        want = pending_derivs.pop_front();
        if (got_der !== want.deriv) begin
          $error("derivative: expected %0d, got %0d", want.deriv, got_der);
          fail_count++;
        end
        if (m_axis_tuser !== want.sat) begin
          $error("saturated: expected %0d, got %0d", want.sat, m_axis_tuser);
          fail_count++;
        end
        if (got_lo !== want.lo) begin
          $error("min_value: expected %0d, got %0d", want.lo, got_lo);
          fail_count++;
        end
        if (got_hi !== want.hi) begin
          $error("max_value: expected %0d, got %0d", want.hi, got_hi);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_out: expected %0d, got %0d", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("spline_derivative_bound: mismatch");
      $finish;
    end
  end

  initial begin
    logic [MIN_DEN_W-1:0] phase_den  [7];
    logic                 phase_kind [7];
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_BASIS_KIND;
    cfg_data      = '0;
    fail_count    = 0;
    cycle_count   = 0;
    gaps_on       = 1'b1;
    basis_sel     = BASIS_BSPLINE;  // register reset values
    min_den       = 1;
    clear_dir_bounds();

    // Directed table: kind, cur, nxt, khi, klo, factor, dir, last, typed, der, sat.
    // First block runs at reset settings (B-spline, min_denominator 1).
    // zero factor, then full-range differences over a zero span
    add_row(BASIS_BSPLINE, 0,    0,    0,    0,    0,   0, 0, 1, 0,    0);
    add_row(BASIS_BSPLINE, VMIN, VMAX, 0,    0,    255, 1, 0, 1, VMAX, 1);
    add_row(BASIS_BSPLINE, VMAX, VMIN, 0,    0,    255, 1, 0, 1, VMIN, 1);
    add_row(BASIS_BSPLINE, VMIN, VMAX, VMAX, VMIN, 0,   2, 0, 1, 0,    0);
    // half step: 1.0 over span 2.0
    add_row(BASIS_BSPLINE, 0,    ONE,  2*ONE, 0,   1,   2, 0, 0, 0,    0);
    // negative span falls back to min_denominator
    add_row(BASIS_BSPLINE, 0,    ONE,  0,    ONE,  1,   3, 0, 0, 0,    0);
    // widest span and widest negative span
    add_row(BASIS_BSPLINE, VMAX, VMIN, VMAX, VMIN, 255, 3, 0, 0, 0,    0);
    add_row(BASIS_BSPLINE, 0,    -1,   VMIN, VMAX, 255, 5, 0, 0, 0,    0);
    // span 1.0 leaves the product as is: edges of the signed range
    add_row(BASIS_BSPLINE, 0,    VMAX, ONE,  0,    1,   4, 0, 1, VMAX, 0);
    add_row(BASIS_BSPLINE, 0,    VMIN, ONE,  0,    1,   4, 0, 1, VMIN, 0);
    add_row(BASIS_BSPLINE, -1,   VMAX, ONE,  0,    1,   4, 0, 1, VMAX, 1);
    add_row(BASIS_BSPLINE, 1,    VMIN, ONE,  0,    1,   5, 0, 1, VMIN, 1);
    // last word on the top direction, then a word after the clear
    add_row(BASIS_BSPLINE, 5,    3,    3*ONE, ONE, 3,   7, 1, 0, 0,    0);
    add_row(BASIS_BSPLINE, 3,    5,    ONE/2, 0,   2,   7, 0, 0, 0,    0);
    // Bezier: knots ignored, product clamped when out of range
    add_row(BASIS_BEZIER,  VMIN, VMAX, 0,    0,    255, 0, 0, 1, VMAX, 1);
    add_row(BASIS_BEZIER,  VMAX, VMIN, 0,    0,    255, 0, 0, 1, VMIN, 1);
    add_row(BASIS_BEZIER,  0,    VMAX, VMIN, VMAX, 1,   6, 0, 1, VMAX, 0);
    add_row(BASIS_BEZIER,  0,    VMIN, 0,    0,    1,   6, 0, 1, VMIN, 0);
    add_row(BASIS_BEZIER,  VMIN, VMAX, 0,    0,    0,   6, 0, 1, 0,    0);
    add_row(BASIS_BEZIER,  -7,   9,    0,    0,    3,   1, 1, 0, 0,    0);
    add_row(BASIS_BEZIER,  100,  -100, 5,    5,    255, 0, 0, 0, 0,    0);

    // random phases: basis and min_denominator, extremes and the zero case
    phase_kind[0] = BASIS_BSPLINE;  phase_den[0] = 1;
    phase_kind[1] = BASIS_BSPLINE;  phase_den[1] = 65536;
    phase_kind[2] = BASIS_BEZIER;   phase_den[2] = 65536;
    phase_kind[3] = BASIS_BSPLINE;  phase_den[3] = 0;
    phase_kind[4] = BASIS_BSPLINE;  phase_den[4] = 17'h1FFFF;
    phase_kind[5] = BASIS_BSPLINE;  phase_den[5] = MIN_DEN_W'($urandom_range(1, 65536));
    phase_kind[6] = BASIS_BEZIER;   phase_den[6] = 1;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind != basis_sel) begin
        drain();
        write_reg(CFG_BASIS_KIND, MIN_DEN_W'(directed_rows[i].kind));
      end
      send_pair(directed_rows[i].pair, directed_rows[i].typed,
                directed_rows[i].t_der, directed_rows[i].t_sat);
    end

    for (int ph = 0; ph < 7; ph++) begin
      drain();
      write_reg(CFG_BASIS_KIND, MIN_DEN_W'(phase_kind[ph]));
      write_reg(CFG_MIN_DEN, phase_den[ph]);
      gaps_on = (ph != 4);  // one long stretch with both sides running flat out
      for (int n = 0; n < PHASE_WORDS; n++) send_pair(random_pair(), 0, 0, 0);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("spline_derivative_bound: match");
    end else begin
      $display("spline_derivative_bound: mismatch");
    end
    $finish;
  end

endmodule
